@@ sv/pvt_pkg.sv @@
// Shared types and constants for the plurality vote tally.
package pvt_pkg;

	localparam int OP_BITS    = 2;
	localparam int VOTE_BITS  = 64;
	localparam int COUNT_BITS = 7;
	localparam int CFG_BITS   = 64;
	localparam int IN_BYTES   = 8;
	localparam int OUT_BITS   = 72;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef enum logic [OP_BITS-1:0] {
		OP_START   = 2'd0,
		OP_CAST    = 2'd1,
		OP_ABSTAIN = 2'd2
	} op_t;

	typedef enum logic {
		REG_CURRENT_VALUE = 1'b0,
		REG_TARGET_VALUE  = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	// control part of the search item that walks down the cell row
	typedef struct packed {
		logic                  valid;
		logic                  found;
		logic                  alloc;
		logic [COUNT_BITS-1:0] count;
	} tok_ctl_t;

endpackage

@@ sv/pvt_cell.sv @@
// One table entry of the tally row: match, allocate or count, then pass the item on.
module pvt_cell #(
	parameter int MAX_ENTRIES = 65,
	parameter int VALUE_BITS  = 64,
	parameter int IDX         = 0,
	localparam int UW         = $clog2(MAX_ENTRIES + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [UW-1:0]          used,
	input  pvt_pkg::tok_ctl_t      ctl_in,
	input  logic [VALUE_BITS-1:0]  val_in,
	output pvt_pkg::tok_ctl_t      ctl_out,
	output logic [VALUE_BITS-1:0]  val_out
);

	localparam logic [UW-1:0] MY_IDX = UW'(IDX);

	logic [VALUE_BITS-1:0]          val_q;
	logic [pvt_pkg::COUNT_BITS-1:0] cnt_q;
	pvt_pkg::tok_ctl_t              ctl_q;
	logic [VALUE_BITS-1:0]          tval_q;

	logic                           live;
	logic                           hit;
	logic                           take;
	logic [pvt_pkg::COUNT_BITS-1:0] inc_cnt;
	pvt_pkg::tok_ctl_t              ctl_nxt;

	always_comb begin
		live    = ctl_in.valid && !ctl_in.found;
		hit     = live && (MY_IDX < used) && (val_q == val_in);
		take    = live && (MY_IDX == used);
		// saturate at the top count
		inc_cnt = (cnt_q == pvt_pkg::COUNT_MAX) ? cnt_q : cnt_q + pvt_pkg::COUNT_BITS'(1);
		ctl_nxt = ctl_in;
		if (hit) begin
			ctl_nxt.found = 1'b1;
			ctl_nxt.count = inc_cnt;
		end else if (take) begin
			ctl_nxt.found = 1'b1;
			ctl_nxt.alloc = 1'b1;
			ctl_nxt.count = pvt_pkg::COUNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			cnt_q <= inc_cnt;
		end else if (take) begin
			val_q <= val_in;
			cnt_q <= pvt_pkg::COUNT_BITS'(1);
		end
		tval_q <= val_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_nxt;
		end
	end

	assign ctl_out = ctl_q;
	assign val_out = tval_q;

endmodule

@@ sv/plurality_vote_tally_top.sv @@
// Plurality vote tally: row of entry cells with a shared winner register.
// Start, cast and abstain launch a search item into the row (the search walks one cell per cycle);
// code 3 goes straight to the result. The result is registered once the item leaves the row.
// Only one item is in flight: a new input is taken only once the last result is loaded.
// Reset clears the fill count, the winner, both registers and all handshake state;
// entry cells need no clearing since only filled entries are compared.
module plurality_vote_tally_top #(
	parameter int MAX_ENTRIES = 65,
	parameter int VALUE_BITS  = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [pvt_pkg::IN_BYTES*8-1:0]      s_tdata,  // vote_value
	input  logic [pvt_pkg::OP_BITS-1:0]         s_tuser,  // operation
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// winner_value, winner_count, table_full
	output logic [pvt_pkg::OUT_BITS-1:0]        m_tdata,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [pvt_pkg::CFG_BITS-1:0]        cfg_data
);

	localparam int UW = $clog2(MAX_ENTRIES + 1);

	pvt_pkg::state_t                state_q;
	pvt_pkg::state_t                state_nxt;
	pvt_pkg::op_t                   op;
	pvt_pkg::tok_ctl_t              chain_ctl [MAX_ENTRIES+1];
	logic [VALUE_BITS-1:0]          chain_val [MAX_ENTRIES+1];
	pvt_pkg::tok_ctl_t              launch_ctl_q;
	logic [VALUE_BITS-1:0]          launch_val_q;
	logic [pvt_pkg::CFG_BITS-1:0]   cur_q;
	logic [pvt_pkg::CFG_BITS-1:0]   tgt_q;
	logic [UW-1:0]                  used_q;
	logic [VALUE_BITS-1:0]          best_value_q;
	logic [pvt_pkg::COUNT_BITS-1:0] best_count_q;
	logic                           drop_q;
	logic                           m_valid_q;
	logic [pvt_pkg::OUT_BITS-1:0]   m_data_q;

	logic                           accept;
	logic                           done_load;
	logic                           chain_done;
	logic                           better;
	logic [pvt_pkg::VOTE_BITS-1:0]  win_value;
	pvt_pkg::tok_ctl_t              end_ctl;
	logic [VALUE_BITS-1:0]          end_val;
	pvt_pkg::tok_ctl_t              launch_nxt;

	assign op         = pvt_pkg::op_t'(s_tuser);
	assign accept     = s_tvalid && s_tready;
	assign end_ctl    = chain_ctl[MAX_ENTRIES];
	assign end_val    = chain_val[MAX_ENTRIES];
	assign chain_done = (state_q == pvt_pkg::ST_RUN) && end_ctl.valid;

	assign chain_ctl[0] = launch_ctl_q;
	assign chain_val[0] = launch_val_q;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		pvt_cell #(
			.MAX_ENTRIES(MAX_ENTRIES),
			.VALUE_BITS (VALUE_BITS),
			.IDX        (i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.used   (used_q),
			.ctl_in (chain_ctl[i]),
			.val_in (chain_val[i]),
			.ctl_out(chain_ctl[i+1]),
			.val_out(chain_val[i+1])
		);
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			pvt_pkg::ST_IDLE: begin
				if (accept) begin
					case (op)
						pvt_pkg::OP_START,
						pvt_pkg::OP_CAST,
						pvt_pkg::OP_ABSTAIN: state_nxt = pvt_pkg::ST_RUN;
						default:             state_nxt = pvt_pkg::ST_DONE;
					endcase
				end
			end
			pvt_pkg::ST_RUN: begin
				if (end_ctl.valid) state_nxt = pvt_pkg::ST_DONE;
			end
			pvt_pkg::ST_DONE: begin
				if (!m_valid_q || m_tready) state_nxt = pvt_pkg::ST_IDLE;
			end
			default: state_nxt = pvt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = (state_q == pvt_pkg::ST_IDLE);
		done_load = (state_q == pvt_pkg::ST_DONE) && (!m_valid_q || m_tready);
		// launch a search item for every operation that votes
		launch_nxt       = '0;
		launch_nxt.valid = accept &&
			(op inside {pvt_pkg::OP_START, pvt_pkg::OP_CAST, pvt_pkg::OP_ABSTAIN});
	end

	always_comb begin
		better = (end_ctl.count > best_count_q) ||
			((end_ctl.count == best_count_q) && (end_val < best_value_q));
		// no vote held yet: report the value in force
		if (best_count_q == '0) begin
			win_value = pvt_pkg::VOTE_BITS'(cur_q[VALUE_BITS-1:0]);
		end else begin
			win_value = pvt_pkg::VOTE_BITS'(best_value_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= pvt_pkg::ST_IDLE;
			launch_ctl_q <= '0;
			cur_q        <= '0;
			tgt_q        <= '0;
			used_q       <= '0;
			best_value_q <= '0;
			best_count_q <= '0;
			drop_q       <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			state_q <= state_nxt;

			if (cfg_we) begin
				case (pvt_pkg::reg_idx_t'(cfg_index))
					pvt_pkg::REG_CURRENT_VALUE: cur_q <= cfg_data;
					pvt_pkg::REG_TARGET_VALUE:  tgt_q <= cfg_data;
					default: ;
				endcase
			end

			launch_ctl_q <= launch_nxt;
			if (accept) begin
				drop_q <= 1'b0;
				case (op)
					pvt_pkg::OP_START: begin
						used_q       <= '0;
						best_value_q <= '0;
						best_count_q <= '0;
					end
					default: ;
				endcase
			end

			// fold the search outcome into the fill count and the winner, or flag a dropped vote
			if (chain_done) begin
				if (end_ctl.found) begin
					used_q <= used_q + UW'(end_ctl.alloc);
					if (better) begin
						best_count_q <= end_ctl.count;
						best_value_q <= end_val;
					end
				end else begin
					drop_q <= 1'b1;
				end
			end

			if (done_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			case (op)
				pvt_pkg::OP_START:   launch_val_q <= tgt_q[VALUE_BITS-1:0];
				pvt_pkg::OP_CAST:    launch_val_q <= s_tdata[VALUE_BITS-1:0];
				pvt_pkg::OP_ABSTAIN: launch_val_q <= cur_q[VALUE_BITS-1:0];
				default:             launch_val_q <= launch_val_q;
			endcase
		end
		if (done_load) begin
			m_data_q <= {drop_q, best_count_q, win_value};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

@@ sv/pvt_checker.sv @@
// Port-level checks for the plurality vote tally, bound to the top level.
module pvt_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [pvt_pkg::OUT_BITS-1:0]   m_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one item in flight: busy right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in flight");

	// no result appears in the cycle right after an accept
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result appeared too early");

	// a full table implies votes are held
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[71] |-> m_tdata[70:64] != 7'd0)
		else $error("dropped vote reported with zero winner count");

endmodule

bind plurality_vote_tally_top pvt_checker u_pvt_checker (.*);

@@ dv/testbench.sv @@
// Self-checking testbench for the plurality vote tally top level.
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	import pvt_pkg::*;

	localparam int TABLE_DEPTH = 65;
	localparam int ITEM_BUDGET = 1050;
	localparam int CYCLE_LIMIT = 600000;
	localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic                  table_full;
		logic [COUNT_BITS-1:0] winner_count;
		logic [VOTE_BITS-1:0]  winner_value;
	} tally_result_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [IN_BYTES*8-1:0]        s_tdata = '0;   // vote_value
	logic [OP_BITS-1:0]           s_tuser = '0;   // operation
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [OUT_BITS-1:0]          m_tdata;        // winner_value, winner_count, table_full
	logic                         cfg_we = 1'b0;
	logic                         cfg_index = 1'b0;
	logic [CFG_BITS-1:0]          cfg_data = '0;

	// mirror of the block's tally state and registers
	logic [VOTE_BITS-1:0]  current_reg;
	logic [VOTE_BITS-1:0]  target_reg;
	logic [VOTE_BITS-1:0]  tbl_value [TABLE_DEPTH];
	logic [COUNT_BITS-1:0] tbl_count [TABLE_DEPTH];
	int unsigned           tbl_used;
	logic [VOTE_BITS-1:0]  best_value;
	logic [COUNT_BITS-1:0] best_count;

	tally_result_t pending_winners [$];
	tally_result_t got_result;
	tally_result_t want_result;
	int            error_count = 0;
	int            items_sent = 0;
	int            cycle_count = 0;
	logic          no_idle = 1'b0;

	plurality_vote_tally_top #(
		.MAX_ENTRIES(TABLE_DEPTH),
		.VALUE_BITS (VOTE_BITS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_tready <= no_idle || ($urandom_range(0, 99) >= 35);
	end

	task automatic report_mismatch(string what, logic [VOTE_BITS-1:0] got,
	                               logic [VOTE_BITS-1:0] want);
		$display("%0t mismatch in %s: got %h, want %h", $time, what, got, want);
		error_count++;
	endtask

	// count one vote; returns 1 when the vote is dropped for a full table
	function automatic logic add_vote(logic [VOTE_BITS-1:0] v);
		int                    hit;
		logic [COUNT_BITS-1:0] c;
		hit = -1;
		for (int i = 0; i < tbl_used; i++)
			if (hit < 0 && tbl_value[i] == v)
				hit = i;
		if (hit < 0) begin
			if (tbl_used >= TABLE_DEPTH)
				return 1'b1;
			hit = tbl_used;
			tbl_value[hit] = v;
			tbl_count[hit] = '0;
			tbl_used++;
		end
		c = tbl_count[hit];
		if (c != COUNT_MAX)
			c++;
		tbl_count[hit] = c;
		if (c > best_count || (c == best_count && v < best_value)) begin
			best_count = c;
			best_value = v;
		end
		return 1'b0;
	endfunction

	function automatic tally_result_t tally_item(logic [OP_BITS-1:0] op,
	                                             logic [VOTE_BITS-1:0] vote);
		tally_result_t r;
		r.table_full = 1'b0;
		case (op)
			OP_START: begin
				tbl_used = 0;
				best_value = '0;
				best_count = '0;
				void'(add_vote(target_reg));
			end
			OP_CAST: r.table_full = add_vote(vote);
			OP_ABSTAIN: r.table_full = add_vote(current_reg);
			default: ;
		endcase
		if (best_count == 0) begin
			r.winner_value = current_reg;
			r.winner_count = '0;
		end else begin
			r.winner_value = best_value;
			r.winner_count = best_count;
		end
		return r;
	endfunction

	function automatic logic [VOTE_BITS-1:0] rand_word();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return VOTE_BITS'($urandom_range(0, 7));
			3: return {32'hFFFF_FFFF, $urandom};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// leaves s_tvalid high on return so back-to-back items need no dip
	task automatic send_ballot(logic [OP_BITS-1:0] op, logic [VOTE_BITS-1:0] vote);
		while (!no_idle && $urandom_range(0, 99) < 35) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= vote;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_winners.push_back(tally_item(op, vote));
		if (op != OP_UNUSED)
			items_sent++;
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (pending_winners.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write both registers while the block is idle
	task automatic set_registers(logic [VOTE_BITS-1:0] cur, logic [VOTE_BITS-1:0] tgt);
		wait_for_results();
		cfg_we <= 1'b1;
		cfg_index <= REG_CURRENT_VALUE;
		cfg_data <= cur;
		@(posedge clk);
		cfg_index <= REG_TARGET_VALUE;
		cfg_data <= tgt;
		@(posedge clk);
		cfg_we <= 1'b0;
		current_reg = cur;
		target_reg = tgt;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_result = m_tdata;
			if (pending_winners.size() == 0) begin
				report_mismatch("unexpected result", got_result.winner_value, '0);
			end else begin
				want_result = pending_winners.pop_front();
				if (got_result.winner_value != want_result.winner_value)
					report_mismatch("winner_value", got_result.winner_value,
					                want_result.winner_value);
				if (got_result.winner_count != want_result.winner_count)
					report_mismatch("winner_count",
					                VOTE_BITS'(got_result.winner_count),
					                VOTE_BITS'(want_result.winner_count));
				if (got_result.table_full != want_result.table_full)
					report_mismatch("table_full",
					                VOTE_BITS'(got_result.table_full),
					                VOTE_BITS'(want_result.table_full));
			end
		end
	end

	// votes before any start, and the no-vote winner
	task automatic test_empty_table();
		send_ballot(OP_UNUSED, '1);
		set_registers('1, '0);
		send_ballot(OP_UNUSED, '0);
		send_ballot(OP_ABSTAIN, '0);
		send_ballot(OP_CAST, '0);
		send_ballot(OP_CAST, '1);
	endtask

	task automatic test_basic_ops();
		set_registers(64'd5, '1);
		send_ballot(OP_START, '0);
		send_ballot(OP_CAST, '0);
		send_ballot(OP_CAST, '0);
		send_ballot(OP_ABSTAIN, '1);
		send_ballot(OP_UNUSED, 64'hAAAA_AAAA_AAAA_AAAA);
		send_ballot(OP_ABSTAIN, '0);
		send_ballot(OP_CAST, 64'd1);
		send_ballot(OP_ABSTAIN, '0);
		send_ballot(OP_CAST, 64'hAAAA_AAAA_AAAA_AAAA);
		send_ballot(OP_CAST, 64'h5555_5555_5555_5555);
		send_ballot(OP_CAST, '1);
		send_ballot(OP_CAST, '1);
		send_ballot(OP_CAST, '1);
		// tie between target and current: smaller value wins
		send_ballot(OP_START, 64'h5555_5555_5555_5555);
		send_ballot(OP_ABSTAIN, '0);
		send_ballot(OP_CAST, 64'd5);
		send_ballot(OP_CAST, '1);
		send_ballot(OP_UNUSED, '0);
	endtask

	task automatic test_full_table();
		logic [VOTE_BITS-1:0] tgt;
		tgt = {1'b1, 31'($urandom), $urandom};
		set_registers(tgt ^ 64'd1, tgt);
		send_ballot(OP_START, rand_word());
		for (int i = 1; i < TABLE_DEPTH; i++)
			send_ballot(OP_CAST, {1'b0, 31'($urandom), 32'(i)});
		send_ballot(OP_CAST, {1'b0, 31'($urandom), 32'(TABLE_DEPTH + 7)});
		send_ballot(OP_ABSTAIN, rand_word());
		send_ballot(OP_CAST, tgt);
		send_ballot(OP_CAST, '0);
	endtask

	// drive two values to the count ceiling; the smaller one must win the tie
	task automatic test_saturation();
		logic [VOTE_BITS-1:0] low_value;
		low_value = {1'b0, 31'($urandom), $urandom};
		set_registers({1'b1, 31'($urandom), $urandom}, rand_word());
		send_ballot(OP_START, '0);
		repeat (130) send_ballot(OP_ABSTAIN, rand_word());
		repeat (128) send_ballot(OP_CAST, low_value);
		send_ballot(OP_ABSTAIN, '0);
	endtask

	task automatic test_random_rounds();
		logic [VOTE_BITS-1:0] pool [80];
		int pool_size;
		int round_len;
		int r;
		int steady_from;
		steady_from = items_sent + $urandom_range(50, 250);
		while (items_sent < ITEM_BUDGET) begin
			no_idle = (items_sent >= steady_from && items_sent < steady_from + 150);
			if ($urandom_range(0, 3) == 0)
				set_registers(rand_word(), rand_word());
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					pool_size = $urandom_range(1, 3);
					round_len = $urandom_range(1, 20);
				end
				4, 5, 6, 7: begin
					pool_size = $urandom_range(4, 10);
					round_len = $urandom_range(5, 40);
				end
				8: begin
					pool_size = 80;
					round_len = 150;
				end
				default: begin
					pool_size = 40;
					round_len = $urandom_range(20, 60);
				end
			endcase
			for (int i = 0; i < pool_size; i++)
				pool[i] = rand_word();
			if ($urandom_range(0, 1) == 0)
				pool[0] = target_reg;
			if ($urandom_range(0, 2) == 0)
				pool[pool_size - 1] = current_reg;
			// an occasional round without a start keeps tallying the old table
			if ($urandom_range(0, 19) != 0)
				send_ballot(OP_START, rand_word());
			for (int k = 0; k < round_len; k++) begin
				r = $urandom_range(0, 99);
				if (r < 60)
					send_ballot(OP_CAST, pool[$urandom_range(0, pool_size - 1)]);
				else if (r < 70)
					send_ballot(OP_CAST, {$urandom, $urandom});
				else if (r < 90)
					send_ballot(OP_ABSTAIN, rand_word());
				else if (r < 96)
					send_ballot(OP_UNUSED, rand_word());
				else
					send_ballot(OP_START, rand_word());
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		current_reg = '0;
		target_reg = '0;
		tbl_used = 0;
		best_value = '0;
		best_count = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_basic_ops();
		test_full_table();
		test_saturation();
		test_random_rounds();
		wait_for_results();
		repeat (TABLE_DEPTH + 8) @(posedge clk);
		if (error_count == 0 && pending_winners.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
